>>> design/sobel_edge_magnitude_normalizer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Sobel edge magnitude normalizer
// Checks are clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_NORMALIZER_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_NORMALIZER_ASSERT_SVH

// cond implies prop in the same cycle
`define SEMN_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("semn same-cycle check failed");

// cond implies prop in the following cycle
`define SEMN_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("semn next-cycle check failed");

`endif

>>> design/semn_pkg.sv
// ---------------------------------------------------------------------------
// semn_pkg
// Types, constants and helpers shared by the Sobel edge normalizer modules.
// ---------------------------------------------------------------------------
package semn_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int DIM_W      = 10;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = 18;
  localparam int MAG_W      = 22;
  localparam int PIX_W      = 8;
  localparam int SQ_W       = 16;
  localparam int PROD_W     = 38;
  localparam int BIT_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINARIZE_ENABLE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_THRESHOLD = 4'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [DIM_W-1:0] DIM_LIMIT_W   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_LIMIT_H   = DIM_W'(MAX_HEIGHT);
  localparam logic [SQ_W-1:0]  NORM_SCALE    = 16'd65025;
  localparam logic [PIX_W-1:0] EDGE_FULL     = 8'd255;
  localparam logic [PIX_W-1:0] THRESH_RESET  = 8'd128;

  typedef struct packed {
    logic              func;
    logic [PIX_W-1:0]  pixel_value;
    logic [ADDR_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_ready;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             binarize;
    logic [PIX_W-1:0] threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RD_MUL,
    ST_SQ_MUL,
    ST_SQ_CMP,
    ST_RD_DONE
  } state_t;

  typedef struct packed {
    logic             lb_write;
    logic [COL_W-1:0] lb_col;
    logic [1:0]       slot;
    logic             rd_issue;
    logic [COL_W-1:0] rd_col;
    logic             rd_first;
    logic             rd_last;
    logic             has_above;
    logic             has_below;
    logic             frame_clear;
    logic             mag_read;
    logic             ready_flag;
    logic             lhs_load;
    logic             sq_mul;
    logic             sq_cmp;
    logic [BIT_W-1:0] sq_bit;
    logic             res_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } status_t;

  function automatic logic [1:0] slot_next(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/sobel_edge_magnitude_normalizer.sv
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_normalizer
// Sobel 3x3 gradient magnitude over a raster frame with max normalization.
// ---------------------------------------------------------------------------
// Usage:
//  item channel: func 0 beats carry raster pixels, func 1 beats request the
//  normalized magnitude at read_index. Only func 1 beats produce a result.
//  cfg channel: index 0/1 set frame width/height (abandons the frame),
//  index 2 enables binarizing, index 3 sets its threshold. Always ready.
//  A pixel beat is taken while the block is idle; at the end of a row the
//  block sweeps the previous row through the window pipeline, and on the
//  last row sweeps that row too. The sweep is set by one line-buffer read
//  per column plus the pipeline drain. A read beat returns its result after
//  one scale multiply, eight square-root steps (a 16x22 multiply and a
//  compare each) and one output-register load; the next beat is taken only
//  after that load. While a result waits in the output register, pixel
//  beats and one more read are taken; that read then holds in its last
//  step and the item channel stops until the result is taken.
//  Reset clears the frame state and loads the register defaults.
// ---------------------------------------------------------------------------
`include "sobel_edge_magnitude_normalizer_assert.svh"

module sobel_edge_magnitude_normalizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  semn_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output semn_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [semn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [semn_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [semn_pkg::DIM_W-1:0] frame_width, frame_height;
  logic                       binarize_enable;
  logic [semn_pkg::PIX_W-1:0] binary_threshold;
  logic                       abandon;
  semn_pkg::cfg_t             cfg;
  semn_pkg::cmd_t             cmd;
  semn_pkg::status_t          status;
  logic                       read_beat;
  logic                       edge_rail;

  assign cfg_ready = 1'b1;
  assign abandon   = cfg_valid && ((cfg_index == semn_pkg::REG_FRAME_WIDTH) ||
                                   (cfg_index == semn_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= semn_pkg::DIM_LIMIT_W;
      frame_height     <= semn_pkg::DIM_LIMIT_H;
      binarize_enable  <= 1'b0;
      binary_threshold <= semn_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        semn_pkg::REG_FRAME_WIDTH:      frame_width      <= cfg_data;
        semn_pkg::REG_FRAME_HEIGHT:     frame_height     <= cfg_data;
        semn_pkg::REG_BINARIZE_ENABLE:  binarize_enable  <= cfg_data[0];
        semn_pkg::REG_BINARY_THRESHOLD: binary_threshold <= cfg_data[semn_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.width     = semn_pkg::eff_dim(frame_width, semn_pkg::DIM_LIMIT_W);
    cfg.height    = semn_pkg::eff_dim(frame_height, semn_pkg::DIM_LIMIT_H);
    cfg.binarize  = binarize_enable;
    cfg.threshold = binary_threshold;
  end

  semn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cfg        (cfg),
    .abandon    (abandon),
    .status     (status),
    .cmd        (cmd)
  );

  semn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign read_beat = item_valid && item_ready && (item.func == semn_pkg::FUNC_READ);
  assign edge_rail = (result.edge_value == '0) || (result.edge_value == semn_pkg::EDGE_FULL);

  `SEMN_ASSERT_NEXT(a_read_holds_off, read_beat, !item_ready)
  `SEMN_ASSERT_NOW(a_not_ready_zero, result_valid && !result.frame_ready, result.edge_value == '0)
  `SEMN_ASSERT_NOW(a_binary_levels, result_valid && binarize_enable, edge_rail)

endmodule

>>> design/semn_ctrl.sv
// ---------------------------------------------------------------------------
// semn_ctrl
// Sequencer: frame position, row sweeps and the readout square-root steps.
// ---------------------------------------------------------------------------
module semn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  semn_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_ready,
  input  semn_pkg::cfg_t    cfg,
  input  logic              abandon,
  input  semn_pkg::status_t status,
  output semn_pkg::cmd_t    cmd
);

  semn_pkg::state_t state, state_next;

  logic [semn_pkg::COL_W-1:0] col;
  logic [semn_pkg::ROW_W-1:0] row;
  logic [1:0]                 slot;
  logic                       ready;
  logic [semn_pkg::DIM_W-1:0] k;
  logic [1:0]                 sw_center;
  logic                       sw_above;
  logic                       sw_below;
  logic                       pend;
  logic [1:0]                 pend_center;
  logic                       pend_above;
  logic [semn_pkg::BIT_W-1:0] bit_idx;

  logic accept, load, rd, row_end, need_prev, need_last, frame_start, sweep_end;

  assign accept      = item_valid && (state == semn_pkg::ST_IDLE);
  assign load        = accept && (item.func == semn_pkg::FUNC_LOAD);
  assign rd          = accept && (item.func == semn_pkg::FUNC_READ);
  assign row_end     = (semn_pkg::DIM_W'(col) + semn_pkg::DIM_W'(1)) >= cfg.width;
  assign need_prev   = (row != '0);
  assign need_last   = (semn_pkg::DIM_W'(row) + semn_pkg::DIM_W'(1)) >= cfg.height;
  assign frame_start = (row == '0) && (col == '0);
  assign sweep_end   = (k == cfg.width);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= semn_pkg::ST_IDLE;
      col     <= '0;
      row     <= '0;
      slot    <= '0;
      ready   <= 1'b0;
      k       <= '0;
      pend    <= 1'b0;
      bit_idx <= '0;
    end else begin
      state <= state_next;
      if (abandon) begin
        col   <= '0;
        row   <= '0;
        slot  <= '0;
        ready <= 1'b0;
      end
      case (state)
        semn_pkg::ST_IDLE: begin
          if (load) begin
            if (frame_start) begin
              ready <= 1'b0;
            end
            if (row_end) begin
              col <= '0;
              k   <= '0;
              if (need_prev) begin
                sw_center   <= semn_pkg::slot_prev(slot);
                sw_above    <= (row >= semn_pkg::ROW_W'(2));
                sw_below    <= 1'b1;
                pend        <= need_last;
                pend_center <= slot;
                pend_above  <= 1'b1;
              end else begin
                sw_center <= slot;
                sw_above  <= 1'b0;
                sw_below  <= 1'b0;
                pend      <= 1'b0;
              end
              if (need_last) begin
                ready <= 1'b1;
                row   <= '0;
                slot  <= '0;
              end else begin
                row  <= row + semn_pkg::ROW_W'(1);
                slot <= semn_pkg::slot_next(slot);
              end
            end else begin
              col <= col + semn_pkg::COL_W'(1);
            end
          end
        end
        semn_pkg::ST_SWEEP: begin
          k <= k + semn_pkg::DIM_W'(1);
        end
        semn_pkg::ST_DRAIN: begin
          if (!status.pipe_busy && pend) begin
            pend      <= 1'b0;
            sw_center <= pend_center;
            sw_above  <= pend_above;
            sw_below  <= 1'b0;
            k         <= '0;
          end
        end
        semn_pkg::ST_RD_MUL: begin
          bit_idx <= semn_pkg::BIT_W'(7);
        end
        semn_pkg::ST_SQ_CMP: begin
          bit_idx <= bit_idx - semn_pkg::BIT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      semn_pkg::ST_IDLE: begin
        if (load && row_end && (need_prev || need_last)) begin
          state_next = semn_pkg::ST_SWEEP;
        end else if (rd) begin
          state_next = semn_pkg::ST_RD_MUL;
        end
      end
      semn_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          state_next = semn_pkg::ST_DRAIN;
        end
      end
      semn_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = pend ? semn_pkg::ST_SWEEP : semn_pkg::ST_IDLE;
        end
      end
      semn_pkg::ST_RD_MUL: state_next = semn_pkg::ST_SQ_MUL;
      semn_pkg::ST_SQ_MUL: state_next = semn_pkg::ST_SQ_CMP;
      semn_pkg::ST_SQ_CMP: begin
        state_next = (bit_idx == '0) ? semn_pkg::ST_RD_DONE : semn_pkg::ST_SQ_MUL;
      end
      semn_pkg::ST_RD_DONE: begin
        if (!status.out_busy) begin
          state_next = semn_pkg::ST_IDLE;
        end
      end
      default: state_next = semn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.lb_col     = col;
    cmd.slot       = (state == semn_pkg::ST_IDLE) ? slot : sw_center;
    cmd.rd_col     = k[semn_pkg::COL_W-1:0];
    cmd.rd_first   = (k == '0);
    cmd.rd_last    = sweep_end;
    cmd.has_above  = sw_above;
    cmd.has_below  = sw_below;
    cmd.ready_flag = ready;
    cmd.sq_bit     = bit_idx;
    item_ready     = 1'b0;
    case (state)
      semn_pkg::ST_IDLE: begin
        item_ready      = 1'b1;
        cmd.lb_write    = load;
        cmd.mag_read    = rd;
        cmd.frame_clear = abandon || (load && frame_start);
      end
      semn_pkg::ST_SWEEP:   cmd.rd_issue = 1'b1;
      semn_pkg::ST_RD_MUL:  cmd.lhs_load = 1'b1;
      semn_pkg::ST_SQ_MUL:  cmd.sq_mul   = 1'b1;
      semn_pkg::ST_SQ_CMP:  cmd.sq_cmp   = 1'b1;
      semn_pkg::ST_RD_DONE: cmd.res_load = !status.out_busy;
      default: begin
      end
    endcase
  end

endmodule

>>> design/semn_dp.sv
// ---------------------------------------------------------------------------
// semn_dp
// Datapath: line buffers, 3x3 window, magnitude store and normalizer.
// ---------------------------------------------------------------------------
module semn_dp (
  input  logic              clk,
  input  logic              rst,
  input  semn_pkg::item_t   item,
  input  semn_pkg::cfg_t    cfg,
  input  semn_pkg::cmd_t    cmd,
  output semn_pkg::status_t status,
  output logic              result_valid,
  input  logic              result_ready,
  output semn_pkg::result_t result
);

  localparam int MAG_DEPTH = semn_pkg::MAX_WIDTH * semn_pkg::MAX_HEIGHT;

  logic [semn_pkg::PIX_W-1:0] lb_rdata [3];

  for (genvar i = 0; i < 3; i++) begin : g_lb
    logic [semn_pkg::PIX_W-1:0] mem [semn_pkg::MAX_WIDTH];
    logic [semn_pkg::PIX_W-1:0] rdata;
    always_ff @(posedge clk) begin
      if (cmd.lb_write && (cmd.slot == 2'(i))) begin
        mem[cmd.lb_col] <= item.pixel_value;
      end
      if (cmd.rd_issue) begin
        rdata <= mem[cmd.rd_col];
      end
    end
    assign lb_rdata[i] = rdata;
  end

  // window columns: [0] top, [1] middle, [2] bottom
  logic [2:0][semn_pkg::PIX_W-1:0] wl, wc, wr, col_in;
  logic rd_v, rd_first_q, rd_zero, win_v, s_v;

  always_comb begin
    col_in    = '0;
    col_in[1] = lb_rdata[cmd.slot];
    if (cmd.has_above) begin
      col_in[0] = lb_rdata[semn_pkg::slot_prev(cmd.slot)];
    end
    if (cmd.has_below) begin
      col_in[2] = lb_rdata[semn_pkg::slot_next(cmd.slot)];
    end
    if (rd_zero) begin
      col_in = '0;
    end
  end

  logic [10:0] px, nx, py, ny;
  logic signed [11:0] gx, gy;
  logic signed [23:0] gx2, gy2;
  logic [23:0] ssum;

  assign px   = 11'(wr[0]) + (11'(wr[1]) << 1) + 11'(wr[2]);
  assign nx   = 11'(wl[0]) + (11'(wl[1]) << 1) + 11'(wl[2]);
  assign py   = 11'(wl[0]) + (11'(wc[0]) << 1) + 11'(wr[0]);
  assign ny   = 11'(wl[2]) + (11'(wc[2]) << 1) + 11'(wr[2]);
  assign gx   = $signed({1'b0, px}) - $signed({1'b0, nx});
  assign gy   = $signed({1'b0, py}) - $signed({1'b0, ny});
  assign gx2  = gx * gx;
  assign gy2  = gy * gy;
  assign ssum = 24'(gx2) + 24'(gy2);

  logic [semn_pkg::MAG_W-1:0]  s_q, max_q, mag_rdata;
  logic [semn_pkg::ADDR_W-1:0] waddr;
  logic [semn_pkg::MAG_W-1:0]  mag_mem [MAG_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      win_v <= 1'b0;
      s_v   <= 1'b0;
      waddr <= '0;
      max_q <= '0;
    end else begin
      rd_v  <= cmd.rd_issue;
      win_v <= rd_v && !rd_first_q;
      s_v   <= win_v;
      if (cmd.frame_clear) begin
        waddr <= '0;
        max_q <= '0;
      end else if (s_v) begin
        waddr <= waddr + semn_pkg::ADDR_W'(1);
        if (s_q > max_q) begin
          max_q <= s_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_q <= cmd.rd_first;
    rd_zero    <= cmd.rd_last;
    if (rd_v) begin
      if (rd_first_q) begin
        wl <= '0;
        wc <= '0;
      end else begin
        wl <= wc;
        wc <= wr;
      end
      wr <= col_in;
    end
    if (win_v) begin
      s_q <= ssum[semn_pkg::MAG_W-1:0];
    end
    if (s_v) begin
      mag_mem[waddr] <= s_q;
    end
    if (cmd.mag_read) begin
      mag_rdata <= mag_mem[item.read_index];
    end
  end

  // readout: bitwise square root of 65025*S/Smax
  logic [19:0]                 area;
  logic                        rd_ok, rd_flag;
  logic [semn_pkg::PROD_W-1:0] lhs, prod;
  logic [semn_pkg::PIX_W-1:0]  edge_q, edge_out;
  logic [semn_pkg::SQ_W-1:0]   esq, tsq, tsq_q;

  assign area = 20'(cfg.width) * 20'(cfg.height);
  assign tsq  = esq + (semn_pkg::SQ_W'(edge_q) << (4'(cmd.sq_bit) + 4'd1))
              + (semn_pkg::SQ_W'(1) << {cmd.sq_bit, 1'b0});

  always_comb begin
    edge_out = edge_q;
    if (!rd_ok) begin
      edge_out = '0;
    end else if (cfg.binarize) begin
      edge_out = (edge_q > cfg.threshold) ? semn_pkg::EDGE_FULL : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mag_read) begin
      rd_ok   <= cmd.ready_flag && (20'(item.read_index) < area) && (max_q != '0);
      rd_flag <= cmd.ready_flag;
    end
    if (cmd.lhs_load) begin
      lhs    <= semn_pkg::PROD_W'(mag_rdata) * semn_pkg::PROD_W'(semn_pkg::NORM_SCALE);
      edge_q <= '0;
      esq    <= '0;
    end
    if (cmd.sq_mul) begin
      tsq_q <= tsq;
      prod  <= semn_pkg::PROD_W'(tsq) * semn_pkg::PROD_W'(max_q);
    end
    if (cmd.sq_cmp && (prod <= lhs)) begin
      edge_q <= edge_q | (semn_pkg::PIX_W'(1) << cmd.sq_bit);
      esq    <= tsq_q;
    end
    if (cmd.res_load) begin
      result.edge_value  <= edge_out;
      result.frame_ready <= rd_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  assign status.pipe_busy = rd_v || win_v || s_v;
  assign status.out_busy  = result_valid && !result_ready;

endmodule
